// ===== rtl/core/tabular_actor_critic_update_top_macros.svh =====
// Assertion macros shared by the tabular actor-critic update RTL.
// Included by the modules that carry concurrent assertions; depends on nothing.
`ifndef TABULAR_ACTOR_CRITIC_UPDATE_TOP_MACROS_SVH
`define TABULAR_ACTOR_CRITIC_UPDATE_TOP_MACROS_SVH

// Checked on every rising edge while reset is released.
`define TACU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define TACU_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/tac_pkg.sv =====
// Shared types, constants and helper functions of the tabular actor-critic update.
// Used by the interfaces and by every module under rtl/core; depends on nothing.
package tac_pkg;

  localparam int unsigned NUM_STATES_DEF  = 1024;
  localparam int unsigned NUM_ACTIONS_DEF = 4;

  localparam int unsigned STATE_IDX_W  = 10;
  localparam int unsigned ACTION_IDX_W = 2;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned PREF_W       = 17;
  localparam int unsigned RATE_W       = 16;
  localparam int unsigned CFG_IDX_W    = 8;
  localparam int unsigned CFG_DATA_W   = 32;

  localparam logic [PREF_W-1:0] PREF_ONE = 17'd65536;

  localparam logic [RATE_W-1:0] RST_ACTOR_UP_RATE   = 16'd6554;
  localparam logic [RATE_W-1:0] RST_CRITIC_RATE     = 16'd6554;
  localparam logic [RATE_W-1:0] RST_ACTOR_DOWN_RATE = 16'd6554;
  localparam logic [RATE_W-1:0] RST_DISCOUNT        = 16'd62259;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTOR_UP_RATE   = 8'd0,
    CFG_CRITIC_RATE     = 8'd1,
    CFG_ACTOR_DOWN_RATE = 8'd2,
    CFG_DISCOUNT        = 8'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [RATE_W-1:0] actor_up_rate;
    logic [RATE_W-1:0] critic_rate;
    logic [RATE_W-1:0] actor_down_rate;
    logic [RATE_W-1:0] discount;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DISC,
    ST_DIFF,
    ST_CRIT,
    ST_VAL,
    ST_PREF,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic capture;
    logic clear_step;
    logic read;
    logic disc;
    logic diff;
    logic crit;
    logic val;
    logic pref;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_full;
  } sts_t;

  // Remainder of a narrow value by a constant modulus, by conditional subtraction.
  function automatic logic [15:0] mod_reduce(logic [15:0] val, int unsigned modulus);
    logic [31:0] rem;
    logic [31:0] m;
    rem = {16'd0, val};
    for (int k = 15; k >= 0; k--) begin
      m = 32'(modulus) << k;
      if (rem >= m) begin
        rem = rem - m;
      end
    end
    return rem[15:0];
  endfunction

endpackage

// ===== rtl/core/tac_ifs.sv =====
// Request channels of the tabular actor-critic update: input, result and register write.
// Depends on tac_pkg for the field widths.
interface tac_in_if;
  logic                                   valid;
  logic                                   ready;
  logic        [tac_pkg::STATE_IDX_W-1:0]  state_index;
  logic        [tac_pkg::ACTION_IDX_W-1:0] action_index;
  logic signed [tac_pkg::VALUE_W-1:0]      reward;
  logic        [tac_pkg::STATE_IDX_W-1:0]  next_state_index;
  logic                                   end_of_episode;

  modport source (
    output valid, state_index, action_index, reward, next_state_index, end_of_episode,
    input  ready
  );
  modport sink (
    input  valid, state_index, action_index, reward, next_state_index, end_of_episode,
    output ready
  );
endinterface

interface tac_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [tac_pkg::VALUE_W-1:0] new_value;
  logic        [tac_pkg::PREF_W-1:0]  new_preference;
  logic                              improved;

  modport source (output valid, new_value, new_preference, improved, input ready);
  modport sink (input valid, new_value, new_preference, improved, output ready);
endinterface

interface tac_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [tac_pkg::CFG_IDX_W-1:0]  index;
  logic [tac_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/tac_cfg.sv =====
// Learning-rate and discount registers with their write decoder.
// Depends on tac_pkg and the tac_cfg_if interface.
module tac_cfg (
  input  logic            clk_i,
  input  logic            rst_ni,
  tac_cfg_if.sink         cfg_i,
  output tac_pkg::cfg_t   cfg_o
);

  tac_pkg::cfg_t cfg_d, cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (tac_pkg::cfg_idx_e'(cfg_i.index))
        tac_pkg::CFG_ACTOR_UP_RATE:   cfg_d.actor_up_rate   = cfg_i.data[tac_pkg::RATE_W-1:0];
        tac_pkg::CFG_CRITIC_RATE:     cfg_d.critic_rate     = cfg_i.data[tac_pkg::RATE_W-1:0];
        tac_pkg::CFG_ACTOR_DOWN_RATE: cfg_d.actor_down_rate = cfg_i.data[tac_pkg::RATE_W-1:0];
        tac_pkg::CFG_DISCOUNT:        cfg_d.discount        = cfg_i.data[tac_pkg::RATE_W-1:0];
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.actor_up_rate   <= tac_pkg::RST_ACTOR_UP_RATE;
      cfg_q.critic_rate     <= tac_pkg::RST_CRITIC_RATE;
      cfg_q.actor_down_rate <= tac_pkg::RST_ACTOR_DOWN_RATE;
      cfg_q.discount        <= tac_pkg::RST_DISCOUNT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/core/tac_ctrl.sv =====
// Sequencer of the tabular actor-critic update: table clearing, then one transition at a time.
// Depends on tac_pkg and the assertion macro header.
`include "tabular_actor_critic_update_top_macros.svh"

module tac_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output tac_pkg::cmd_t cmd_o,
  input  tac_pkg::sts_t sts_i
);

  tac_pkg::state_e state_d, state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tac_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      tac_pkg::ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) begin
          state_d = tac_pkg::ST_IDLE;
        end
      end
      tac_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = tac_pkg::ST_READ;
        end
      end
      tac_pkg::ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = tac_pkg::ST_DISC;
      end
      tac_pkg::ST_DISC: begin
        cmd_o.disc = 1'b1;
        state_d    = tac_pkg::ST_DIFF;
      end
      tac_pkg::ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = tac_pkg::ST_CRIT;
      end
      tac_pkg::ST_CRIT: begin
        cmd_o.crit = 1'b1;
        state_d    = tac_pkg::ST_VAL;
      end
      tac_pkg::ST_VAL: begin
        cmd_o.val = 1'b1;
        state_d   = tac_pkg::ST_PREF;
      end
      tac_pkg::ST_PREF: begin
        cmd_o.pref = 1'b1;
        state_d    = tac_pkg::ST_DONE;
      end
      tac_pkg::ST_DONE: begin
        if (!sts_i.out_full) begin
          cmd_o.done = 1'b1;
          state_d    = tac_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tac_pkg::ST_IDLE;
      end
    endcase
  end

  `TACU_ASSERT(a_accept_starts_read, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> (state_q == tac_pkg::ST_READ), "accepted request did not start a table read")
  `TACU_ASSERT(a_single_command, clk_i, rst_ni, $onehot0(cmd_o), "more than one datapath command in a cycle")
  `TACU_ASSERT(a_done_needs_room, clk_i, rst_ni, cmd_o.done |-> !sts_i.out_full, "result loaded over an untaken result")
  `TACU_ASSERT_ALWAYS(a_no_request_in_reset, clk_i, !rst_ni |-> !in_ready_o, "request taken while reset is held")

endmodule

// ===== rtl/core/tac_dp.sv =====
// Datapath of the tabular actor-critic update: value and preference memories,
// multiply stages, saturation and the result register. Depends on tac_pkg, tac_out_if and macros.
`include "tabular_actor_critic_update_top_macros.svh"

module tac_dp #(
  parameter int unsigned NUM_STATES  = tac_pkg::NUM_STATES_DEF,
  parameter int unsigned NUM_ACTIONS = tac_pkg::NUM_ACTIONS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  tac_pkg::cmd_t                           cmd_i,
  output tac_pkg::sts_t                           sts_o,
  input  tac_pkg::cfg_t                           rates_i,
  input  logic        [tac_pkg::STATE_IDX_W-1:0]  state_index_i,
  input  logic        [tac_pkg::ACTION_IDX_W-1:0] action_index_i,
  input  logic signed [tac_pkg::VALUE_W-1:0]      reward_i,
  input  logic        [tac_pkg::STATE_IDX_W-1:0]  next_state_index_i,
  input  logic                                    end_of_episode_i,
  tac_out_if.source                               out_o
);

  localparam int unsigned PREF_DEPTH = NUM_STATES * NUM_ACTIONS;
  localparam int unsigned SW = $clog2(NUM_STATES);
  localparam int unsigned AW = $clog2(NUM_ACTIONS);
  localparam int unsigned PW = $clog2(PREF_DEPTH);

  localparam logic signed [35:0] NV_MAX = 36'sd2147483647;
  localparam logic signed [35:0] NV_MIN = -36'sd2147483648;

  logic signed [31:0] vmem [NUM_STATES];
  logic        [16:0] pmem [PREF_DEPTH];

  logic [PW-1:0] clr_cnt_q;

  logic [15:0] s_red, ns_red, a_red;
  logic        [SW-1:0] s_q, ns_q;
  logic        [AW-1:0] a_q;
  logic signed [31:0]   rew_q;
  logic                 end_q;
  logic        [PW-1:0] paddr;

  logic signed [31:0] vs_q, vns_q;
  logic        [16:0] p_q;

  logic signed [48:0] disc_prod_d, disc_prod_q;
  logic signed [32:0] disc_val;
  logic signed [33:0] diff_d, diff_q;
  logic signed [17:0] pup_q, pdn_q;
  logic signed [50:0] crit_prod_d, crit_prod_q;
  logic signed [34:0] crit_delta;
  logic signed [35:0] nv_wide;
  logic signed [31:0] nv_sat, nv_q;
  logic               improved, imp_q;
  logic signed [17:0] pref_op;
  logic        [15:0] pref_rate;
  logic signed [34:0] pref_prod_d, pref_prod_q;
  logic signed [18:0] pref_delta;
  logic signed [19:0] np_wide;
  logic        [16:0] np;

  logic               v_we;
  logic        [SW-1:0] v_waddr;
  logic signed [31:0]   v_wdata;

  logic               out_valid_q;
  logic signed [31:0] out_value_q;
  logic        [16:0] out_pref_q;
  logic               out_imp_q;

  assign s_red  = tac_pkg::mod_reduce(16'(state_index_i), NUM_STATES);
  assign ns_red = tac_pkg::mod_reduce(16'(next_state_index_i), NUM_STATES);
  assign a_red  = tac_pkg::mod_reduce(16'(action_index_i), NUM_ACTIONS);
  assign paddr  = PW'(s_q) * PW'(NUM_ACTIONS) + PW'(a_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear_step) begin
      clr_cnt_q <= clr_cnt_q + PW'(1);
    end
  end

  assign sts_o.clear_last = (clr_cnt_q == PW'(PREF_DEPTH - 1));
  assign sts_o.out_full   = out_valid_q && !out_o.ready;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      s_q   <= s_red[SW-1:0];
      ns_q  <= ns_red[SW-1:0];
      a_q   <= a_red[AW-1:0];
      rew_q <= reward_i;
      end_q <= end_of_episode_i;
    end
  end

  // The value table has one write port shared by the clearing pass and the update.
  assign v_we    = (cmd_i.clear_step && (clr_cnt_q < PW'(NUM_STATES))) || cmd_i.val;
  assign v_waddr = cmd_i.clear_step ? clr_cnt_q[SW-1:0] : s_q;
  assign v_wdata = cmd_i.clear_step ? '0 : nv_sat;

  always_ff @(posedge clk_i) begin
    if (v_we) begin
      vmem[v_waddr] <= v_wdata;
    end
    if (cmd_i.read) begin
      vs_q  <= vmem[s_q];
      vns_q <= vmem[ns_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_step) begin
      pmem[clr_cnt_q] <= '0;
    end else if (cmd_i.done) begin
      pmem[paddr] <= np;
    end
    if (cmd_i.read) begin
      p_q <= pmem[paddr];
    end
  end

  // Products carry the rounding half so that the shift by 16 rounds half up.
  assign disc_prod_d = 49'(vns_q) * 49'($signed({1'b0, rates_i.discount})) + 49'sd32768;
  assign disc_val    = $signed(disc_prod_q[48:16]);
  assign diff_d      = 34'(rew_q) + (end_q ? 34'sd0 : 34'(disc_val)) - 34'(vs_q);

  assign crit_prod_d = 51'(diff_q) * 51'($signed({1'b0, rates_i.critic_rate})) + 51'sd32768;
  assign crit_delta  = $signed(crit_prod_q[50:16]);
  assign nv_wide     = 36'(vs_q) + 36'(crit_delta);

  always_comb begin
    if (nv_wide > NV_MAX) begin
      nv_sat = 32'sh7FFF_FFFF;
    end else if (nv_wide < NV_MIN) begin
      nv_sat = -32'sh8000_0000;
    end else begin
      nv_sat = nv_wide[31:0];
    end
  end

  assign improved = nv_sat > vs_q;

  assign pref_op     = imp_q ? pup_q : pdn_q;
  assign pref_rate   = imp_q ? rates_i.actor_up_rate : rates_i.actor_down_rate;
  assign pref_prod_d = 35'(pref_op) * 35'($signed({1'b0, pref_rate})) + 35'sd32768;
  assign pref_delta  = $signed(pref_prod_q[34:16]);
  assign np_wide     = $signed(20'(p_q)) + 20'(pref_delta);

  always_comb begin
    if (np_wide < 20'sd0) begin
      np = '0;
    end else if (np_wide > 20'sd65536) begin
      np = tac_pkg::PREF_ONE;
    end else begin
      np = np_wide[16:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.disc) begin
      disc_prod_q <= disc_prod_d;
    end
    if (cmd_i.diff) begin
      diff_q <= diff_d;
      pup_q  <= $signed(18'(tac_pkg::PREF_ONE)) - $signed(18'(p_q));
      pdn_q  <= -$signed(18'(p_q));
    end
    if (cmd_i.crit) begin
      crit_prod_q <= crit_prod_d;
    end
    if (cmd_i.val) begin
      nv_q  <= nv_sat;
      imp_q <= improved;
    end
    if (cmd_i.pref) begin
      pref_prod_q <= pref_prod_d;
    end
    if (cmd_i.done) begin
      out_value_q <= nv_q;
      out_pref_q  <= np;
      out_imp_q   <= imp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.done) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.new_value      = out_value_q;
  assign out_o.new_preference = out_pref_q;
  assign out_o.improved       = out_imp_q;

  `TACU_ASSERT(a_result_from_done, clk_i, rst_ni, $rose(out_valid_q) |-> $past(cmd_i.done), "result appeared without a completed update")
  `TACU_ASSERT(a_pref_in_range, clk_i, rst_ni, out_valid_q |-> (out_pref_q <= tac_pkg::PREF_ONE), "preference above one")

endmodule

// ===== rtl/core/tabular_actor_critic_update_top.sv =====
// Tabular actor-critic update: each accepted request runs the chain of table read, three
// multiply stages and table writes; a new request is taken only once the previous result
// is loaded, which waits while an untaken result is held. After reset both tables are
// cleared, one preference entry per cycle for all NUM_STATES*NUM_ACTIONS entries, with
// input ready low; register writes are always taken.
module tabular_actor_critic_update_top #(
  parameter int unsigned NUM_STATES  = tac_pkg::NUM_STATES_DEF,
  parameter int unsigned NUM_ACTIONS = tac_pkg::NUM_ACTIONS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tac_cfg_if.sink   cfg_i,
  tac_in_if.sink    in_i,
  tac_out_if.source out_o
);

  tac_pkg::cfg_t rates;
  tac_pkg::cmd_t cmd;
  tac_pkg::sts_t sts;
  logic          in_ready;

  assign in_i.ready = in_ready;

  tac_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (rates)
  );

  tac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  tac_dp #(
    .NUM_STATES  (NUM_STATES),
    .NUM_ACTIONS (NUM_ACTIONS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .rates_i            (rates),
    .state_index_i      (in_i.state_index),
    .action_index_i     (in_i.action_index),
    .reward_i           (in_i.reward),
    .next_state_index_i (in_i.next_state_index),
    .end_of_episode_i   (in_i.end_of_episode),
    .out_o              (out_o)
  );

endmodule
